// ----- design/srqs_pkg.sv -----
// Package with payload types, register indexes, sequencer states and coefficient tables.
package srqs_pkg;

    typedef struct packed {
        logic       kind;
        logic [7:0] adc_sample;
        logic [7:0] load_ratio;
    } t_in_item;

    typedef struct packed {
        logic [8:0] ratio;
        logic       sample_valid;
        logic       recomputed;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_MUL_DD,
        ST_MUL_C2,
        ST_MUL_C1,
        ST_DONE
    } t_state;

    localparam logic [2:0] REG_ADC_OFFSET      = 3'd0;
    localparam logic [2:0] REG_MARGIN_SELECT   = 3'd1;
    localparam logic [2:0] REG_RISE_HYSTERESIS = 3'd2;
    localparam logic [2:0] REG_VALID_LOW       = 3'd3;
    localparam logic [2:0] REG_VALID_HIGH      = 3'd4;

    localparam logic       KIND_MEASURE = 1'b0;
    localparam logic       KIND_LOAD    = 1'b1;

    localparam logic [7:0] CENTER_CODE  = 8'd115;
    localparam logic [8:0] RATIO_FLOOR  = 9'd64;
    localparam logic [8:0] RATIO_RESET  = 9'd72;

    localparam logic [22:0] COEF0 [4] = '{23'h536778, 23'h545DCE, 23'h5516E1, 23'h559E24};
    localparam logic [15:0] COEF1 [4] = '{16'hD5DB, 16'hD4AD, 16'hDC1D, 16'hDC93};
    localparam logic [8:0]  COEF2 [4] = '{9'h1E5, 9'h1E0, 9'h1F5, 9'h1F5};

endpackage

// ----- design/sar_ratio_quadratic_select.sv -----
// Top level: converter ratio selection from a battery ADC sample with a shared multiplier.
//
// Requests enter on the input channel (i_in_valid, o_in_ready, i_in_data) and one result
// per request leaves on the output channel (o_out_valid, i_out_ready, o_out_data).
// A measurement request has the offset added, is checked against the validity window
// and, when the hysteresis rule calls for it, runs the quadratic through one shared
// 16 by 16 multiplier: d*d, c2*d*d and c1*d in states ST_MUL_DD, ST_MUL_C2 and
// ST_MUL_C1 in turn, accumulated in a 32-bit register. The result register is loaded
// in ST_DONE, reached through ST_CHECK and the multiply states for a recomputed
// measurement, through ST_CHECK alone for a measurement without recompute and
// straight from ST_IDLE for a load request.
// The block accepts one request at a time; o_in_ready is high only while the
// sequencer is idle. The result register lets a new request be taken while the last
// result still waits. If the receiver stalls, the finished request waits in its last
// step until the result register is free, and the state is updated only then.
// Configuration is written through the APB port; pready is always high.
// Synchronous active-low reset sets the ratio to 72, clears the sample history
// and loads the register reset values.
module sar_ratio_quadratic_select
    import srqs_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  t_in_item         i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_out_item        o_out_data,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [4:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    t_state      r_state, n_state;

    logic [7:0]  r_adc_offset;
    logic [1:0]  r_margin;
    logic [7:0]  r_hyst;
    logic [7:0]  r_valid_low;
    logic [7:0]  r_valid_high;

    logic [8:0]  r_ratio;
    logic [7:0]  r_last;

    t_in_item    r_item;
    logic [7:0]  r_s;
    logic [7:0]  r_d;
    logic        r_above;
    logic        r_valid;
    logic        r_recomp;
    logic [15:0] r_dd;
    logic [31:0] r_acc;

    logic        r_out_valid;
    t_out_item   r_out;

    logic        cfg_wr;
    logic [2:0]  cfg_idx;
    logic        in_acc;
    logic        out_free;
    logic        win_ok;
    logic        need_recomp;
    logic [8:0]  last_plus_hyst;
    logic [15:0] mul_a;
    logic [15:0] mul_b;
    logic [31:0] mul_p;
    logic [15:0] acc_hi;
    logic [8:0]  new_ratio;

    assign pready      = 1'b1;
    assign cfg_wr      = psel && penable && pwrite;
    assign cfg_idx     = paddr[4:2];
    assign in_acc      = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_comb begin
        case (cfg_idx)
            REG_ADC_OFFSET:      prdata = {24'd0, r_adc_offset};
            REG_MARGIN_SELECT:   prdata = {30'd0, r_margin};
            REG_RISE_HYSTERESIS: prdata = {24'd0, r_hyst};
            REG_VALID_LOW:       prdata = {24'd0, r_valid_low};
            REG_VALID_HIGH:      prdata = {24'd0, r_valid_high};
            default:             prdata = 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_adc_offset <= 8'd0;
            r_margin     <= 2'd0;
            r_hyst       <= 8'd1;
            r_valid_low  <= 8'd0;
            r_valid_high <= 8'd255;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_ADC_OFFSET:      r_adc_offset <= pwdata[7:0];
                REG_MARGIN_SELECT:   r_margin     <= pwdata[1:0];
                REG_RISE_HYSTERESIS: r_hyst       <= pwdata[7:0];
                REG_VALID_LOW:       r_valid_low  <= pwdata[7:0];
                REG_VALID_HIGH:      r_valid_high <= pwdata[7:0];
                default: begin
                end
            endcase
        end
    end

    assign win_ok         = (r_s >= r_valid_low) && (r_s <= r_valid_high);
    assign last_plus_hyst = {1'b0, r_last} + {1'b0, r_hyst};
    assign need_recomp    = (r_last == 8'd0) || (r_s < r_last)
                            || ({1'b0, r_s} > last_plus_hyst);

    always_comb begin
        case (r_state)
            ST_MUL_DD: begin
                mul_a = {8'd0, r_d};
                mul_b = {8'd0, r_d};
            end
            ST_MUL_C2: begin
                mul_a = {7'd0, COEF2[r_margin]};
                mul_b = r_dd;
            end
            ST_MUL_C1: begin
                mul_a = COEF1[r_margin];
                mul_b = {8'd0, r_d};
            end
            default: begin
                mul_a = 16'd0;
                mul_b = 16'd0;
            end
        endcase
    end

    assign mul_p     = mul_a * mul_b;
    assign acc_hi    = r_acc[31:16];
    assign new_ratio = (acc_hi < {7'd0, RATIO_FLOOR}) ? RATIO_FLOOR : acc_hi[8:0];

    always_comb begin
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_state = (i_in_data.kind == KIND_LOAD) ? ST_DONE : ST_CHECK;
                end
            end
            ST_CHECK: begin
                n_state = (win_ok && need_recomp) ? ST_MUL_DD : ST_DONE;
            end
            ST_MUL_DD: begin
                n_state = ST_MUL_C2;
            end
            ST_MUL_C2: begin
                n_state = ST_MUL_C1;
            end
            ST_MUL_C1: begin
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    r_item   <= i_in_data;
                    r_s      <= i_in_data.adc_sample + r_adc_offset;
                    r_valid  <= 1'b0;
                    r_recomp <= 1'b0;
                end
            end
            ST_CHECK: begin
                r_valid  <= win_ok;
                r_recomp <= win_ok && need_recomp;
                r_above  <= (r_s >= CENTER_CODE);
                r_d      <= (r_s >= CENTER_CODE) ? (r_s - CENTER_CODE) : (CENTER_CODE - r_s);
                r_acc    <= {9'd0, COEF0[r_margin]};
            end
            ST_MUL_DD: begin
                r_dd <= mul_p[15:0];
            end
            ST_MUL_C2: begin
                r_acc <= r_acc + mul_p;
            end
            ST_MUL_C1: begin
                r_acc <= r_above ? (r_acc - mul_p) : (r_acc + mul_p);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ratio     <= RATIO_RESET;
            r_last      <= 8'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (r_state == ST_DONE && out_free) begin
                r_out_valid <= 1'b1;
                if (r_item.kind == KIND_LOAD) begin
                    r_ratio <= {1'b0, r_item.load_ratio};
                    r_out   <= '{ratio: {1'b0, r_item.load_ratio},
                                 sample_valid: 1'b0, recomputed: 1'b0};
                end else if (r_recomp) begin
                    r_ratio <= new_ratio;
                    if (r_last == 8'd0 || new_ratio != r_ratio) begin
                        r_last <= r_s;
                    end
                    r_out <= '{ratio: new_ratio, sample_valid: 1'b1, recomputed: 1'b1};
                end else begin
                    r_out <= '{ratio: r_ratio, sample_valid: r_valid, recomputed: 1'b0};
                end
            end
        end
    end

endmodule

// ----- tb/sv/sar_ratio_quadratic_select_tb.sv -----
// Testbench for sar_ratio_quadratic_select: directed and random requests against a predictor.
module sar_ratio_quadratic_select_tb;
    import srqs_pkg::*;

    localparam int unsigned MID_CODE  = 115;
    localparam int unsigned MIN_RATIO = 64;

    typedef struct {
        bit         is_cfg;
        logic [2:0] reg_idx;
        logic [7:0] reg_val;
        t_in_item   req;
        bit         has_fixed;
        t_out_item  fixed;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    t_in_item    i_in_data;
    logic        o_out_valid;
    logic        i_out_ready;
    t_out_item   o_out_data;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    logic [7:0] cfg_offset;
    logic [1:0] cfg_sel;
    logic [7:0] cfg_hyst;
    logic [7:0] cfg_lo;
    logic [7:0] cfg_hi;
    logic [8:0] m_ratio;
    logic [7:0] m_last;

    t_out_item ratio_q [$];
    t_row      dir_rows [$];
    int        mismatches = 0;
    bit        quiet = 1'b0;

    sar_ratio_quadratic_select DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #2000000;
        $display("TEST FAILED");
        $finish;
    end

    function automatic logic [8:0] quad_eval(input logic [7:0] s, input logic [1:0] sel);
        logic [31:0] c0;
        logic [31:0] c1;
        logic [31:0] c2;
        logic [31:0] d;
        logic [31:0] acc;
        logic        above;
        case (sel)
            2'd0: begin c0 = 32'h536778; c1 = 32'h0D5DB; c2 = 32'h1E5; end
            2'd1: begin c0 = 32'h545DCE; c1 = 32'h0D4AD; c2 = 32'h1E0; end
            2'd2: begin c0 = 32'h5516E1; c1 = 32'h0DC1D; c2 = 32'h1F5; end
            default: begin c0 = 32'h559E24; c1 = 32'h0DC93; c2 = 32'h1F5; end
        endcase
        above = (s >= MID_CODE);
        d = above ? (32'(s) - MID_CODE) : (MID_CODE - 32'(s));
        acc = above ? (c0 - c1 * d) : (c0 + c1 * d);
        acc = acc + c2 * (d * d);
        acc = acc >> 16;
        if (acc < MIN_RATIO) begin
            acc = MIN_RATIO;
        end
        return acc[8:0];
    endfunction

    function automatic t_out_item ratio_predict(input t_in_item rq);
        t_out_item  res;
        logic [7:0] s;
        logic [8:0] nr;
        res = '0;
        if (rq.kind == KIND_LOAD) begin
            m_ratio = {1'b0, rq.load_ratio};
        end else begin
            s = rq.adc_sample + cfg_offset;
            if (s >= cfg_lo && s <= cfg_hi) begin
                res.sample_valid = 1'b1;
                if (m_last == 8'd0 || s < m_last
                        || {1'b0, s} > {1'b0, m_last} + {1'b0, cfg_hyst}) begin
                    nr = quad_eval(s, cfg_sel);
                    res.recomputed = 1'b1;
                    if (m_last == 8'd0 || nr != m_ratio) begin
                        m_last = s;
                    end
                    m_ratio = nr;
                end
            end
        end
        res.ratio = m_ratio;
        return res;
    endfunction

    task automatic add_cfg(input logic [2:0] idx, input logic [7:0] val);
        t_row r;
        r = '{default: '0};
        r.is_cfg  = 1'b1;
        r.reg_idx = idx;
        r.reg_val = val;
        dir_rows.push_back(r);
    endtask

    task automatic add_req(input logic k, input logic [7:0] smp, input logic [7:0] ld);
        t_row r;
        r = '{default: '0};
        r.req.kind       = k;
        r.req.adc_sample = smp;
        r.req.load_ratio = ld;
        dir_rows.push_back(r);
    endtask

    task automatic add_fixed(input logic k, input logic [7:0] smp, input logic [7:0] ld,
                             input logic [8:0] ratio, input logic vld, input logic rc);
        t_row r;
        r = '{default: '0};
        r.req.kind             = k;
        r.req.adc_sample       = smp;
        r.req.load_ratio       = ld;
        r.has_fixed            = 1'b1;
        r.fixed.ratio          = ratio;
        r.fixed.sample_valid   = vld;
        r.fixed.recomputed     = rc;
        dir_rows.push_back(r);
    endtask

    task automatic send_req(input t_in_item rq, input bit has_fixed, input t_out_item fixed);
        t_out_item want;
        if (!quiet) begin
            while ($urandom_range(0, 99) < 28) begin
                i_in_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_in_valid <= 1'b1;
        i_in_data  <= rq;
        do @(posedge i_clk); while (!o_in_ready);
        want = ratio_predict(rq);
        ratio_q.push_back(has_fixed ? fixed : want);
    endtask

    task automatic drain_pipe();
        i_in_valid <= 1'b0;
        while (ratio_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= {24'd0, val};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_ADC_OFFSET:      cfg_offset = val;
            REG_MARGIN_SELECT:   cfg_sel    = val[1:0];
            REG_RISE_HYSTERESIS: cfg_hyst   = val;
            REG_VALID_LOW:       cfg_lo     = val;
            REG_VALID_HIGH:      cfg_hi     = val;
            default: ;
        endcase
    endtask

    always @(posedge i_clk) begin
        i_out_ready <= quiet || ($urandom_range(0, 99) >= 28);
    end

    always @(posedge i_clk) begin : result_check
        t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (ratio_q.size() == 0) begin
                if (mismatches < 10) begin
                    $display("unexpected result: ratio=%0d valid=%0b recomputed=%0b",
                             o_out_data.ratio, o_out_data.sample_valid,
                             o_out_data.recomputed);
                end
                mismatches++;
            end else begin
                want = ratio_q.pop_front();
                if (want.ratio !== o_out_data.ratio
                        || want.sample_valid !== o_out_data.sample_valid
                        || want.recomputed !== o_out_data.recomputed) begin
                    if (mismatches < 10) begin
                        $display({"mismatch: expected ratio=%0d valid=%0b recomputed=%0b,",
                                  " got ratio=%0d valid=%0b recomputed=%0b"},
                                 want.ratio, want.sample_valid, want.recomputed,
                                 o_out_data.ratio, o_out_data.sample_valid,
                                 o_out_data.recomputed);
                    end
                    mismatches++;
                end
            end
        end
    end

    initial begin : stimulus
        t_in_item   rq;
        t_out_item  none;
        int         span;
        int         delta;
        logic [7:0] lo;
        logic [7:0] hi;
        logic [7:0] hyst;
        logic [7:0] offs;

        none        = '0;
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in_data   <= '0;
        i_out_ready <= 1'b0;
        psel        <= 1'b0;
        penable     <= 1'b0;
        pwrite      <= 1'b0;
        paddr       <= '0;
        pwdata      <= '0;
        cfg_offset  = 8'd0;
        cfg_sel     = 2'd0;
        cfg_hyst    = 8'd1;
        cfg_lo      = 8'd0;
        cfg_hi      = 8'd255;
        m_ratio     = RATIO_RESET;
        m_last      = 8'd0;

        add_fixed(KIND_LOAD, 8'd0, 8'd0, 9'd0, 1'b0, 1'b0);
        add_fixed(KIND_LOAD, 8'd0, 8'd255, 9'd255, 1'b0, 1'b0);
        add_fixed(KIND_MEASURE, 8'd115, 8'd0, 9'd83, 1'b1, 1'b1);
        add_fixed(KIND_MEASURE, 8'd115, 8'd0, 9'd83, 1'b1, 1'b0);
        add_fixed(KIND_MEASURE, 8'd116, 8'd0, 9'd83, 1'b1, 1'b0);
        add_req(KIND_MEASURE, 8'd117, 8'd0);
        add_req(KIND_MEASURE, 8'd114, 8'd0);
        add_req(KIND_MEASURE, 8'd255, 8'hFF);
        add_req(KIND_MEASURE, 8'd0, 8'd0);
        add_req(KIND_MEASURE, 8'd0, 8'd0);
        add_fixed(KIND_LOAD, 8'hFF, 8'hAA, 9'd170, 1'b0, 1'b0);
        add_req(KIND_MEASURE, 8'd1, 8'h55);
        add_cfg(REG_ADC_OFFSET, 8'h80);
        add_cfg(REG_MARGIN_SELECT, 8'd3);
        add_cfg(REG_RISE_HYSTERESIS, 8'd0);
        add_cfg(REG_VALID_LOW, 8'd100);
        add_cfg(REG_VALID_HIGH, 8'd150);
        add_req(KIND_MEASURE, 8'd227, 8'd0);
        add_req(KIND_MEASURE, 8'd228, 8'd0);
        add_req(KIND_MEASURE, 8'd22, 8'd0);
        add_req(KIND_MEASURE, 8'd23, 8'd0);
        add_req(KIND_MEASURE, 8'd250, 8'd0);
        add_cfg(REG_ADC_OFFSET, 8'h7F);
        add_cfg(REG_MARGIN_SELECT, 8'd1);
        add_cfg(REG_RISE_HYSTERESIS, 8'd255);
        add_cfg(REG_VALID_LOW, 8'd0);
        add_cfg(REG_VALID_HIGH, 8'd255);
        add_req(KIND_MEASURE, 8'd255, 8'd0);
        add_req(KIND_MEASURE, 8'd129, 8'd0);
        add_req(KIND_MEASURE, 8'd200, 8'd0);
        add_cfg(REG_MARGIN_SELECT, 8'd2);
        add_cfg(REG_VALID_LOW, 8'd200);
        add_cfg(REG_VALID_HIGH, 8'd100);
        add_req(KIND_MEASURE, 8'd73, 8'd0);
        add_req(KIND_MEASURE, 8'd229, 8'd0);
        add_req(KIND_LOAD, 8'd0, 8'h55);
        add_cfg(REG_ADC_OFFSET, 8'd0);
        add_cfg(REG_VALID_LOW, 8'd130);
        add_cfg(REG_VALID_HIGH, 8'd130);
        add_req(KIND_MEASURE, 8'd130, 8'd0);
        add_req(KIND_MEASURE, 8'd131, 8'd0);

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i]) begin
            if (dir_rows[i].is_cfg) begin
                drain_pipe();
                write_reg(dir_rows[i].reg_idx, dir_rows[i].reg_val);
            end else begin
                send_req(dir_rows[i].req, dir_rows[i].has_fixed, dir_rows[i].fixed);
            end
        end

        for (int p = 0; p < 9; p++) begin
            drain_pipe();
            case (p)
                0: offs = 8'd0;
                1: offs = 8'h7F;
                3: offs = 8'h80;
                default: offs = 8'($urandom_range(0, 255));
            endcase
            case (p)
                2: hyst = 8'd0;
                6: hyst = 8'd255;
                default: hyst = 8'($urandom_range(0, 6));
            endcase
            case (p)
                5: begin lo = 8'd200; hi = 8'd100; end
                7: begin lo = 8'($urandom_range(0, 255)); hi = lo; end
                8: begin
                    lo = 8'($urandom_range(0, 90));
                    hi = 8'($urandom_range(160, 255));
                end
                default: begin lo = 8'd0; hi = 8'd255; end
            endcase
            write_reg(REG_ADC_OFFSET, offs);
            write_reg(REG_MARGIN_SELECT, 8'(p % 4));
            write_reg(REG_RISE_HYSTERESIS, hyst);
            write_reg(REG_VALID_LOW, lo);
            write_reg(REG_VALID_HIGH, hi);
            quiet = (p == 4);
            for (int n = 0; n < 50; n++) begin
                if (p == 2 && n == 25) begin
                    drain_pipe();
                end
                rq.kind       = ($urandom_range(0, 99) < 15) ? KIND_LOAD : KIND_MEASURE;
                rq.adc_sample = 8'($urandom_range(0, 255));
                rq.load_ratio = 8'($urandom_range(0, 255));
                if (rq.kind == KIND_MEASURE && $urandom_range(0, 99) < 60) begin
                    span  = int'(cfg_hyst) + 8;
                    delta = int'($urandom_range(0, span)) - 4;
                    rq.adc_sample = 8'(int'(m_last) + delta - int'($signed(cfg_offset)));
                end
                send_req(rq, 1'b0, none);
            end
            quiet = 1'b0;
        end

        drain_pipe();
        if (mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ----- files.f -----
design/srqs_pkg.sv
design/sar_ratio_quadratic_select.sv
tb/sv/sar_ratio_quadratic_select_tb.sv
